### rtl/fifo_price_level_matcher_defines.svh
// ----------------------------------------------------------------------------
// fifo_price_level_matcher_defines
// assertion macros used by the fifo_price_level_matcher top module
// ----------------------------------------------------------------------------
`ifndef FIFO_PRICE_LEVEL_MATCHER_DEFINES_SVH
`define FIFO_PRICE_LEVEL_MATCHER_DEFINES_SVH

`ifndef SYNTH

// expression holds at every clock edge out of reset
`define FPLM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FPLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FPLM_ASSERT_ALWAYS(label, expr, msg)
`define FPLM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/fplm_pkg.sv
// ----------------------------------------------------------------------------
// fplm_pkg
// types and constants of the price level matcher
// ----------------------------------------------------------------------------
package fplm_pkg;

    localparam int LEVEL_DEPTH_DEFAULT = 16;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    localparam logic KIND_FILL    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [31:0]        id;
        logic [31:0]        qty;
        logic signed [31:0] price;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic update;
    } cell_cmd_t;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic        update;
        logic [31:0] upd_qty;
    } queue_ctl_t;

    typedef struct packed {
        logic               result_kind;
        logic [31:0]        aggressor_id;
        logic [31:0]        passive_id;
        logic               fill_side;
        logic signed [31:0] trade_price;
        logic [31:0]        fill_quantity;
        logic [47:0]        fill_time;
        logic [31:0]        total_filled;
        logic               level_empty;
        logic               rejected;
        logic               last;
    } result_t;

endpackage

### rtl/fplm_ifs.sv
// ----------------------------------------------------------------------------
// fplm_ifs
// valid/ready channels for order items and result items
// ----------------------------------------------------------------------------
interface fplm_order_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [31:0]        order_id;
    logic               order_side;
    logic [31:0]        quantity;
    logic signed [31:0] limit_price;
    logic [47:0]        time_stamp;

    modport source (
        output valid, operation, order_id, order_side, quantity, limit_price, time_stamp,
        input  ready
    );
    modport sink (
        input  valid, operation, order_id, order_side, quantity, limit_price, time_stamp,
        output ready
    );
endinterface

interface fplm_result_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [31:0]        aggressor_id;
    logic [31:0]        passive_id;
    logic               fill_side;
    logic signed [31:0] trade_price;
    logic [31:0]        fill_quantity;
    logic [47:0]        fill_time;
    logic [31:0]        total_filled;
    logic               level_empty;
    logic               rejected;
    logic               last;

    modport source (
        output valid, result_kind, aggressor_id, passive_id, fill_side, trade_price,
               fill_quantity, fill_time, total_filled, level_empty, rejected, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, aggressor_id, passive_id, fill_side, trade_price,
               fill_quantity, fill_time, total_filled, level_empty, rejected, last,
        output ready
    );
endinterface

### rtl/fplm_cell.sv
// ----------------------------------------------------------------------------
// fplm_cell
// one resting order slot; loads a new order, takes its neighbor on a pop,
// or rewrites its quantity after a partial fill
// ----------------------------------------------------------------------------
module fplm_cell
    import fplm_pkg::*;
(
    input  logic        clk,
    input  cell_cmd_t   cmd,
    input  entry_t      in_entry,
    input  entry_t      nbr,
    input  logic [31:0] upd_qty,
    output entry_t      entry
);

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            entry_reg <= in_entry;
        end
        else if (cmd.shift)
        begin
            entry_reg <= nbr;
        end
        else if (cmd.update)
        begin
            entry_reg.qty <= upd_qty;
        end
    end

    assign entry = entry_reg;

endmodule

### rtl/fplm_queue.sv
// ----------------------------------------------------------------------------
// fplm_queue
// row of order cells, head at cell zero, tail written at the fill count
// ----------------------------------------------------------------------------
module fplm_queue
    import fplm_pkg::*;
#(
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEFAULT,
    parameter int CW          = $clog2(LEVEL_DEPTH + 1)
)
(
    input  logic          clk,
    input  queue_ctl_t    ctl,
    input  logic [CW-1:0] count,
    input  entry_t        in_entry,
    output entry_t        head
);

    entry_t cell_q [LEVEL_DEPTH];

    for (genvar i = 0; i < LEVEL_DEPTH; i++)
    begin : g_cell
        cell_cmd_t cmd;
        entry_t    nbr;

        assign cmd.load   = ctl.push && (count == CW'(i));
        assign cmd.shift  = ctl.pop;
        assign cmd.update = ctl.update && (i == 0);

        if (i == LEVEL_DEPTH - 1)
        begin : g_end
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_q[i + 1];
        end

        fplm_cell u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .in_entry (in_entry),
            .nbr      (nbr),
            .upd_qty  (ctl.upd_qty),
            .entry    (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

### rtl/fifo_price_level_matcher.sv
// ----------------------------------------------------------------------------
// fifo_price_level_matcher
// one price level: add appends a resting order, match consumes from the head
// ----------------------------------------------------------------------------
// add: summary registered in the cycle after the transfer; next item then taken
// match: head steps in turn (fill, partial fill or zero-quantity drop), each
//   held while the output is not free, then a summary; no new order is taken
//   until then, and each step works on the single head cell that the chain shifts into
// reset: control, fill count and output valid cleared, level empty; cell
//   contents are not cleared
// ----------------------------------------------------------------------------
`include "fifo_price_level_matcher_defines.svh"

module fifo_price_level_matcher
    import fplm_pkg::*;
#(
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    fplm_order_if.sink   orders,
    fplm_result_if.source results
);

    localparam int CW = $clog2(LEVEL_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MATCH = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   agg_id_reg, agg_id_next;
    logic          side_reg, side_next;
    logic [31:0]   left_reg, left_next;
    logic [31:0]   total_reg, total_next;
    logic [47:0]   time_reg, time_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    queue_ctl_t    qctl;
    entry_t        in_entry;
    entry_t        head;
    logic          out_free;
    logic          accept;
    logic          full;

    assign out_free     = !out_valid_reg || results.ready;
    assign orders.ready = (state_reg == ST_IDLE) && out_free;
    assign accept       = orders.valid && orders.ready;
    assign full         = (count_reg == CW'(LEVEL_DEPTH));

    assign in_entry.id    = orders.order_id;
    assign in_entry.qty   = orders.quantity;
    assign in_entry.price = orders.limit_price;

    fplm_queue #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .CW          (CW)
    ) u_queue (
        .clk      (clk),
        .ctl      (qctl),
        .count    (count_reg),
        .in_entry (in_entry),
        .head     (head)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        agg_id_next = agg_id_reg;
        side_next   = side_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        time_next   = time_reg;
        out_next    = out_reg;
        qctl        = '0;
        out_valid_next = results.ready ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (orders.operation == OP_ADD)
                    begin
                        if (!full)
                        begin
                            qctl.push  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        out_next             = '0;
                        out_next.result_kind = KIND_SUMMARY;
                        out_next.level_empty = (count_next == '0);
                        out_next.rejected    = full;
                        out_next.last        = 1'b1;
                        out_valid_next       = 1'b1;
                    end
                    else
                    begin
                        agg_id_next = orders.order_id;
                        side_next   = orders.order_side;
                        left_next   = orders.quantity;
                        time_next   = orders.time_stamp;
                        total_next  = '0;
                        state_next  = ST_MATCH;
                    end
                end
            end
            ST_MATCH:
            begin
                if (out_free)
                begin
                    if ((left_reg == '0) || (count_reg == '0))
                    begin
                        out_next              = '0;
                        out_next.result_kind  = KIND_SUMMARY;
                        out_next.total_filled = total_reg;
                        out_next.level_empty  = (count_reg == '0);
                        out_next.last         = 1'b1;
                        out_valid_next        = 1'b1;
                        state_next            = ST_IDLE;
                    end
                    else if (head.qty == '0)
                    begin
                        qctl.pop   = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else if (left_reg >= head.qty)
                    begin
                        qctl.pop               = 1'b1;
                        count_next             = count_reg - 1'b1;
                        total_next             = total_reg + head.qty;
                        left_next              = left_reg - head.qty;
                        out_next               = '0;
                        out_next.result_kind   = KIND_FILL;
                        out_next.aggressor_id  = agg_id_reg;
                        out_next.passive_id    = head.id;
                        out_next.fill_side     = side_reg;
                        out_next.trade_price   = head.price;
                        out_next.fill_quantity = head.qty;
                        out_next.fill_time     = time_reg;
                        out_valid_next         = 1'b1;
                    end
                    else
                    begin
                        qctl.update  = 1'b1;
                        qctl.upd_qty = head.qty - left_reg;
                        total_next   = total_reg + left_reg;
                        left_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        agg_id_reg <= agg_id_next;
        side_reg   <= side_next;
        left_reg   <= left_next;
        total_reg  <= total_next;
        time_reg   <= time_next;
        out_reg    <= out_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.result_kind   = out_reg.result_kind;
    assign results.aggressor_id  = out_reg.aggressor_id;
    assign results.passive_id    = out_reg.passive_id;
    assign results.fill_side     = out_reg.fill_side;
    assign results.trade_price   = out_reg.trade_price;
    assign results.fill_quantity = out_reg.fill_quantity;
    assign results.fill_time     = out_reg.fill_time;
    assign results.total_filled  = out_reg.total_filled;
    assign results.level_empty   = out_reg.level_empty;
    assign results.rejected      = out_reg.rejected;
    assign results.last          = out_reg.last;

    `FPLM_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(LEVEL_DEPTH), "fill count over depth")
    `FPLM_ASSERT_ALWAYS(a_push_pop_excl, !(qctl.push && qctl.pop), "push and pop together")
    `FPLM_ASSERT_NEXT(a_pop_count, qctl.pop, count_reg == $past(count_reg) - 1'b1, "pop count")
    `FPLM_ASSERT_NEXT(a_match_enter, accept && (orders.operation == OP_MATCH), state_reg == ST_MATCH, "match not started")

endmodule
